>>> rtl/hsv_to_rgb_converter_assert.svh
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Shared property forms for the converter checks.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// Consequent must hold at the delay n after the antecedent
`define HSVRGB_ASSERT_DELAY(label, clk, rst_n, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error("assertion failed: label");

// Consequent must hold whenever the antecedent holds
`define HSVRGB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

`endif

>>> rtl/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Transaction types, sector codes, scaling constants and the hue split.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

  localparam int unsigned DegPerSector = 60;
  localparam int unsigned NumSectors   = 6;
  localparam int unsigned FracFull     = 255;
  localparam int unsigned ScalePqt     = DegPerSector * FracFull;
  // Reciprocal of ScalePqt in 2^-30 units, rounded down
  localparam int unsigned RecipShift   = 30;
  localparam int unsigned RecipMul     = (1 << RecipShift) / ScalePqt;

  typedef struct packed {
    logic [8:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsv_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_out_t;

  // Hue sectors, named by the colours they run between
  typedef enum logic [2:0] {
    SEC_R_Y = 3'd0,
    SEC_Y_G = 3'd1,
    SEC_G_C = 3'd2,
    SEC_C_B = 3'd3,
    SEC_B_M = 3'd4,
    SEC_M_R = 3'd5
  } sector_t;

  typedef struct packed {
    sector_t    sect;
    logic [5:0] rem;
  } hue_split_t;

  // Split a hue into its sector and the degrees into that sector
  function automatic hue_split_t hue_split(input logic [8:0] hue);
    hue_split_t res;
    logic [3:0] cnt;
    logic [8:0] base;
    cnt = '0;
    for (int k = 1; k <= 8; k++) begin
      if (hue >= 9'(k * DegPerSector)) begin
        cnt = cnt + 4'd1;
      end
    end
    base = 9'(cnt * DegPerSector);
    res.rem = 6'(hue - base);
    if (cnt >= 4'(NumSectors)) begin
      res.sect = sector_t'(3'(cnt - 4'(NumSectors)));
    end else begin
      res.sect = sector_t'(3'(cnt));
    end
    return res;
  endfunction

endpackage

>>> rtl/hsvrgb_div15300.sv
// ----------------------------------------------------------------------------
// Constant divider by 15300
// Two-stage reciprocal multiply with a single remainder correction.
// ----------------------------------------------------------------------------
module hsvrgb_div15300
  import hsvrgb_pkg::*;
(
  input  logic        clk,
  input  logic [21:0] num,
  output logic [7:0]  quot
);

  logic [38:0] prod;
  logic [7:0]  est_r, est_nxt;
  logic [21:0] num_r;
  logic [21:0] back;
  logic [21:0] rem;

  // Estimate the quotient; it is exact or one short
  assign prod    = 39'(num) * 39'(RecipMul);
  assign est_nxt = prod[RecipShift +: 8];

  // Hold the estimate alongside its numerator
  always_ff @(posedge clk) begin
    est_r <= est_nxt;
    num_r <= num;
  end

  // Correct the estimate by one where the remainder is a full divisor
  assign back = 22'(est_r) * 22'(ScalePqt);
  assign rem  = num_r - back;
  assign quot = (rem >= 22'(ScalePqt)) ? est_r + 8'd1 : est_r;

endmodule

>>> rtl/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter
// out_valid is registered alongside each result, the valid bits moving with the data.
// Throughput: one transaction per cycle; busy stays low, no stalls.
// Depth is set by the two chained multiplies and the two-stage divider.
// Reset clears the stage valid bits only; no result appears until fed.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_assert.svh"

module hsv_to_rgb_converter
  import hsvrgb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  hsv_in_t  in_data,
  output logic     out_valid,
  output rgb_out_t out_data
);

  logic [4:0]  vld_r, vld_nxt;

  hue_split_t  split;
  sector_t     sect1_r, sect2_r, sect3_r, sect4_r;
  logic [5:0]  rem1_r;
  logic [7:0]  sat1_r;
  logic [7:0]  bri1_r, bri2_r, bri3_r, bri4_r;
  logic [13:0] rs2_r, rsc2_r;
  logic [7:0]  nsat2_r;
  logic [21:0] nq3_r, nt3_r;
  logic [15:0] np3_r;
  logic [16:0] psum;
  logic [7:0]  p4_r;
  logic [7:0]  qv, tv;
  rgb_out_t    out_r, out_nxt;

  // Never refuse a transaction
  assign busy = 1'b0;

  // Advance valid bits with the data
  assign vld_nxt = {vld_r[3:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Stage 1: split hue into sector and remainder
  assign split = hue_split(in_data.hue);

  always_ff @(posedge clk) begin
    sect1_r <= split.sect;
    rem1_r  <= split.rem;
    sat1_r  <= in_data.saturation;
    bri1_r  <= in_data.brightness;
  end

  // Stage 2: weight saturation by the fraction and its complement
  always_ff @(posedge clk) begin
    rs2_r   <= 14'(rem1_r) * 14'(sat1_r);
    rsc2_r  <= 14'(6'(DegPerSector) - rem1_r) * 14'(sat1_r);
    nsat2_r <= 8'(FracFull) - sat1_r;
    sect2_r <= sect1_r;
    bri2_r  <= bri1_r;
  end

  // Stage 3: scale brightness into the p, q and t numerators
  always_ff @(posedge clk) begin
    nq3_r   <= 22'(bri2_r) * 22'(14'(ScalePqt) - rs2_r);
    nt3_r   <= 22'(bri2_r) * 22'(14'(ScalePqt) - rsc2_r);
    np3_r   <= 16'(bri2_r) * 16'(nsat2_r);
    sect3_r <= sect2_r;
    bri3_r  <= bri2_r;
  end

  // Stage 4: divide p by 255, exact for every product of two 8-bit codes
  assign psum = 17'(np3_r) + 17'(np3_r[15:8]) + 17'd1;

  always_ff @(posedge clk) begin
    p4_r    <= psum[15:8];
    sect4_r <= sect3_r;
    bri4_r  <= bri3_r;
  end

  // Stages 4 and 5: divide q and t by 15300
  hsvrgb_div15300 u_div_q (
    .clk  (clk),
    .num  (nq3_r),
    .quot (qv)
  );

  hsvrgb_div15300 u_div_t (
    .clk  (clk),
    .num  (nt3_r),
    .quot (tv)
  );

  // Stage 5: route p, q, t and v by sector
  always_comb begin
    case (sect4_r)
      SEC_R_Y: out_nxt = '{red: bri4_r, green: tv,     blue: p4_r};
      SEC_Y_G: out_nxt = '{red: qv,     green: bri4_r, blue: p4_r};
      SEC_G_C: out_nxt = '{red: p4_r,   green: bri4_r, blue: tv};
      SEC_C_B: out_nxt = '{red: p4_r,   green: qv,     blue: bri4_r};
      SEC_B_M: out_nxt = '{red: tv,     green: p4_r,   blue: bri4_r};
      default: out_nxt = '{red: bri4_r, green: p4_r,   blue: qv};
    endcase
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = vld_r[4];
  assign out_data  = out_r;

  // Checks: strobe timing, grey on zero saturation, v always present
  `HSVRGB_ASSERT_DELAY(a_latency, clk, rst_n, start && !busy, 5, out_valid)
  `HSVRGB_ASSERT_DELAY(a_grey, clk, rst_n, start && !busy && in_data.saturation == 8'd0, 5, out_data.red == $past(in_data.brightness, 5) && out_data.green == $past(in_data.brightness, 5) && out_data.blue == $past(in_data.brightness, 5))
  `HSVRGB_ASSERT_DELAY(a_value_kept, clk, rst_n, start && !busy, 5, out_data.red == $past(in_data.brightness, 5) || out_data.green == $past(in_data.brightness, 5) || out_data.blue == $past(in_data.brightness, 5))

endmodule

>>> verif/hsv_to_rgb_converter_tb.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives pixels through the converter with random gaps between transactions
// and checks every output pixel against an integer model of the conversion.
// Covers every hue sector and its boundaries, grey and black pixels, and hue
// codes above 359, which wrap round the colour circle.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_tb;
  import hsvrgb_pkg::*;

  localparam int unsigned NumRandom  = 1100;
  localparam int unsigned BurstLen   = 40;
  localparam int unsigned DrainLimit = 200;
  localparam int unsigned SettleCyc  = 10;

  // Expected pixels in order of acceptance, with the conversion that makes them
  class rgb_scoreboard;
    rgb_out_t    expected_rgb[$];
    int unsigned n_accepted;
    int unsigned n_checked;
    int unsigned n_fail;

    function new();
      n_accepted = 0;
      n_checked  = 0;
      n_fail     = 0;
    endfunction

    // Integer HSV to RGB conversion, truncating p, q and t towards zero
    function rgb_out_t convert(input hsv_in_t px);
      rgb_out_t    rgb;
      sector_t     sect;
      int unsigned h;
      int unsigned s;
      int unsigned v;
      int unsigned r;
      int unsigned p;
      int unsigned q;
      int unsigned t;
      h    = px.hue;
      s    = px.saturation;
      v    = px.brightness;
      sect = sector_t'((h / DegPerSector) % NumSectors);
      r    = h % DegPerSector;
      p    = (v * (FracFull - s)) / FracFull;
      q    = (v * (ScalePqt - r * s)) / ScalePqt;
      t    = (v * (ScalePqt - (DegPerSector - r) * s)) / ScalePqt;
      case (sect)
        SEC_R_Y: rgb = '{red: v[7:0], green: t[7:0], blue: p[7:0]};
        SEC_Y_G: rgb = '{red: q[7:0], green: v[7:0], blue: p[7:0]};
        SEC_G_C: rgb = '{red: p[7:0], green: v[7:0], blue: t[7:0]};
        SEC_C_B: rgb = '{red: p[7:0], green: q[7:0], blue: v[7:0]};
        SEC_B_M: rgb = '{red: t[7:0], green: p[7:0], blue: v[7:0]};
        default: rgb = '{red: v[7:0], green: p[7:0], blue: q[7:0]};
      endcase
      return rgb;
    endfunction

    function void note_pixel(input hsv_in_t px);
      expected_rgb.push_back(convert(px));
      n_accepted++;
    endfunction

    function void check_pixel(input rgb_out_t got);
      rgb_out_t want;
      if (expected_rgb.size() == 0) begin
        $error("unexpected output pixel r=%0d g=%0d b=%0d", got.red, got.green, got.blue);
        n_fail++;
        return;
      end
      want = expected_rgb.pop_front();
      n_checked++;
      if (got.red !== want.red) begin
        $error("red mismatch: expected %0d, got %0d", want.red, got.red);
        n_fail++;
      end
      if (got.green !== want.green) begin
        $error("green mismatch: expected %0d, got %0d", want.green, got.green);
        n_fail++;
      end
      if (got.blue !== want.blue) begin
        $error("blue mismatch: expected %0d, got %0d", want.blue, got.blue);
        n_fail++;
      end
    endfunction

    function int unsigned pending();
      return expected_rgb.size();
    endfunction
  endclass

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     start     = 1'b0;
  hsv_in_t  in_data   = '0;
  logic     busy;
  logic     out_valid;
  rgb_out_t out_data;

  rgb_scoreboard sb = new();

  hsv_to_rgb_converter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Note each accepted transaction from the port values at the edge
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      sb.note_pixel(in_data);
    end
  end

  // Check each output strobe against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_pixel(out_data);
    end
  end

  function automatic hsv_in_t make_pixel(input int unsigned h, input int unsigned s,
                                         input int unsigned v);
    hsv_in_t px;
    px.hue        = 9'(h);
    px.saturation = 8'(s);
    px.brightness = 8'(v);
    return px;
  endfunction

  // Bias towards the ends of the range now and then
  function automatic int unsigned pick_code();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 255;
      2:       return $urandom_range(0, 3);
      3:       return $urandom_range(252, 255);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic hsv_in_t random_pixel();
    int unsigned h;
    case ($urandom_range(0, 9))
      0:       h = $urandom_range(0, 511);
      1:       h = 60 * $urandom_range(0, 8) + $urandom_range(0, 1) * 59;
      default: h = $urandom_range(0, 359);
    endcase
    if (h > 511) begin
      h = 511;
    end
    return make_pixel(h, pick_code(), pick_code());
  endfunction

  // Hold start low for the gap, then present the pixel until it is taken
  task automatic send_pixel(input hsv_in_t px, input int unsigned gap);
    if (gap != 0) begin
      start   <= 1'b0;
      in_data <= hsv_in_t'($urandom);
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
  endtask

  initial begin
    hsv_in_t     directed[$];
    int unsigned gap_max;
    int unsigned drain;
    directed = '{
      make_pixel(0, 255, 255),   make_pixel(59, 255, 255),  make_pixel(60, 255, 255),
      make_pixel(119, 255, 255), make_pixel(120, 255, 255), make_pixel(179, 255, 255),
      make_pixel(180, 255, 255), make_pixel(239, 255, 255), make_pixel(240, 255, 255),
      make_pixel(299, 255, 255), make_pixel(300, 255, 255), make_pixel(359, 255, 255),
      make_pixel(30, 0, 200),    make_pixel(200, 0, 255),   make_pixel(90, 255, 0),
      make_pixel(0, 0, 0),       make_pixel(360, 200, 180), make_pixel(511, 255, 255),
      make_pixel(425, 128, 77),  make_pixel(45, 1, 254),    make_pixel(270, 254, 1),
      make_pixel(150, 128, 128)
    };
    gap_max = 0;

    // Hold reset, then release it
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Sector boundaries, grey, black and wrapped hues back to back
    foreach (directed[i]) begin
      send_pixel(directed[i], 0);
    end

    // Random pixels in bursts, some with no gaps at all
    for (int unsigned i = 0; i < NumRandom; i++) begin
      if (i % BurstLen == 0) begin
        gap_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
      end
      send_pixel(random_pixel(), $urandom_range(0, gap_max));
    end
    start   <= 1'b0;
    in_data <= '0;

    // Drain the pipeline, then idle for SettleCyc to catch strays
    drain = 0;
    while (sb.pending() != 0 && drain < DrainLimit) begin
      @(posedge clk);
      drain++;
    end
    repeat (SettleCyc) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d output pixels never arrived", sb.pending());
      sb.n_fail++;
    end

    $display("Sent %0d pixels over all six hue sectors, wrapped hues and grey levels;",
             sb.n_accepted);
    $display("checked %0d output pixels, %0d field mismatches or missing results.",
             sb.n_checked, sb.n_fail);
    if (sb.n_fail == 0) begin
      $display("PASS hsv_to_rgb_converter");
    end else begin
      $display("FAIL hsv_to_rgb_converter");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("FAIL hsv_to_rgb_converter");
    $finish;
  end

endmodule
